// ===== hw/rtl/stl_pkg.sv =====
package stl_pkg;

  localparam int unsigned SourceBytesDef = 4096;
  localparam int unsigned TokPosW        = 13;
  localparam int unsigned ValueW         = 31;
  localparam int unsigned KwCount        = 10;
  localparam int unsigned FifoDepth      = 4;
  localparam int unsigned FifoPtrW       = $clog2(FifoDepth);
  localparam int unsigned FifoCntW       = $clog2(FifoDepth + 1);

  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  typedef enum logic [4:0] {
    KIND_NUMBER = 5'd0,
    KIND_IDENT  = 5'd1,
    KIND_PLUS   = 5'd2,
    KIND_MINUS  = 5'd3,
    KIND_STAR   = 5'd4,
    KIND_SLASH  = 5'd5,
    KIND_ASSIGN = 5'd6,
    KIND_LPAREN = 5'd7,
    KIND_RPAREN = 5'd8,
    KIND_LBRACE = 5'd9,
    KIND_RBRACE = 5'd10,
    KIND_SEMI   = 5'd11,
    KIND_COMMA  = 5'd12,
    KIND_PRINT  = 5'd13,
    KIND_VAR    = 5'd14,
    KIND_IF     = 5'd15,
    KIND_ELSE   = 5'd16,
    KIND_WHILE  = 5'd17,
    KIND_FOR    = 5'd18,
    KIND_FUNC   = 5'd19,
    KIND_RETURN = 5'd20,
    KIND_TRUE   = 5'd21,
    KIND_FALSE  = 5'd22,
    KIND_EOF    = 5'd23,
    KIND_ERROR  = 5'd24
  } token_kind_e;

  // Keyword text, right-justified: the first character sits in the highest used byte.
  localparam logic [47:0] KwText [KwCount] = '{
    48'("print"), 48'("var"), 48'("if"), 48'("else"), 48'("while"),
    48'("for"), 48'("func"), 48'("return"), 48'("true"), 48'("false")
  };
  localparam logic [2:0] KwLen [KwCount] = '{
    3'd5, 3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd6, 3'd4, 3'd5
  };
  localparam int unsigned KwTrueIdx = 8;

  typedef struct packed {
    token_kind_e         kind;
    logic [ValueW-1:0]   value;
    logic [TokPosW-1:0]  start;
    logic [TokPosW-1:0]  length;
  } token_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } beat_t;

  typedef struct packed {
    logic [1:0] count;
    beat_t      first;
    beat_t      second;
  } push_t;

endpackage

// ===== hw/rtl/stl_lexer_core.sv =====
module stl_lexer_core #(
  parameter int unsigned SourceBytes = stl_pkg::SourceBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  input  logic           eos_i,
  output stl_pkg::push_t push_o
);
  import stl_pkg::*;

  localparam int unsigned PosW = $clog2(SourceBytes + 1);
  localparam int unsigned ExtW = (PosW > TokPosW) ? PosW : TokPosW;
  localparam logic [PosW-1:0] PosMax = PosW'(SourceBytes);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSlash = 8'h2f;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_NUM     = 5'b00010,
    MODE_IDENT   = 5'b00100,
    MODE_SLASH   = 5'b01000,
    MODE_COMMENT = 5'b10000
  } lexer_mode_e;

  lexer_mode_e       mode_q, mode_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [KwCount-1:0] cand_q, cand_d;
  logic [PosW-1:0]   start_q, start_d;
  logic [PosW-1:0]   len_q, len_d;
  logic [PosW-1:0]   pos_q, pos_d;

  logic              is_digit, is_alpha, is_blank;
  logic [ValueW+3:0] prod;
  token_t            pend, a_tok, b_tok;
  logic              pend_vld, a_vld, b_vld, do_start;

  function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] v);
    return (v < PosMax) ? v + PosW'(1) : v;
  endfunction

  function automatic logic [TokPosW-1:0] to_tok(input logic [PosW-1:0] v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return e[TokPosW-1:0];
  endfunction

  function automatic logic [KwCount-1:0] kw_filter(input logic [KwCount-1:0] mask,
                                                   input logic [PosW-1:0]    idx,
                                                   input logic [7:0]         c);
    logic [KwCount-1:0] r;
    logic [47:0]        txt;
    int                 sh;
    r = '0;
    for (int k = 0; k < KwCount; k++) begin
      if (mask[k] && idx < PosW'(KwLen[k])) begin
        sh  = (int'(KwLen[k]) - 1 - int'(idx[2:0])) * 8;
        txt = KwText[k] >> sh;
        r[k] = (txt[7:0] == c);
      end
    end
    return r;
  endfunction

  function automatic token_kind_e symbol_kind(input logic [7:0] c);
    case (c)
      8'h2b:   return KIND_PLUS;
      8'h2d:   return KIND_MINUS;
      8'h2a:   return KIND_STAR;
      8'h3d:   return KIND_ASSIGN;
      8'h28:   return KIND_LPAREN;
      8'h29:   return KIND_RPAREN;
      8'h7b:   return KIND_LBRACE;
      8'h7d:   return KIND_RBRACE;
      8'h3b:   return KIND_SEMI;
      8'h2c:   return KIND_COMMA;
      default: return KIND_ERROR;
    endcase
  endfunction

  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_alpha = ((byte_i >= 8'h61) && (byte_i <= 8'h7a)) ||
                    ((byte_i >= 8'h41) && (byte_i <= 8'h5a)) || (byte_i == 8'h5f);
  assign is_blank = (byte_i == ChSpace) || (byte_i == ChTab) ||
                    (byte_i == ChLf) || (byte_i == ChCr);

  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (ValueW + 4)'(byte_i[3:0]);

  // Token held in the mode registers, as it stands before this beat.
  always_comb begin
    pend        = '0;
    pend.start  = to_tok(start_q);
    pend.length = to_tok(len_q);
    pend_vld    = 1'b0;
    unique case (mode_q)
      MODE_NUM: begin
        pend_vld   = 1'b1;
        pend.kind  = KIND_NUMBER;
        pend.value = acc_q;
      end
      MODE_IDENT: begin
        pend_vld  = 1'b1;
        pend.kind = KIND_IDENT;
        for (int k = 0; k < KwCount; k++) begin
          if (cand_q[k] && len_q == PosW'(KwLen[k])) begin
            pend.kind  = token_kind_e'(5'(KIND_PRINT) + 5'(k));
            pend.value = ValueW'(k == KwTrueIdx);
          end
        end
      end
      MODE_SLASH: begin
        pend_vld    = 1'b1;
        pend.kind   = KIND_SLASH;
        pend.length = TokPosW'(1);
      end
      default: pend_vld = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cand_d   = cand_q;
    start_d  = start_q;
    len_d    = len_q;
    pos_d    = pos_q;
    a_tok    = pend;
    a_vld    = 1'b0;
    b_tok    = '0;
    b_vld    = 1'b0;
    do_start = 1'b0;

    if (eos_i) begin
      a_vld       = pend_vld;
      b_vld       = 1'b1;
      b_tok.kind  = KIND_EOF;
      b_tok.start = to_tok(pos_q);
      mode_d      = MODE_IDLE;
      acc_d       = '0;
      cand_d      = '0;
      start_d     = '0;
      len_d       = '0;
      pos_d       = '0;
    end else begin
      pos_d = sat_inc(pos_q);
      unique case (mode_q)
        MODE_NUM: begin
          if (is_digit) begin
            acc_d = (prod > (ValueW + 4)'(ValueMax)) ? ValueMax : prod[ValueW-1:0];
            len_d = sat_inc(len_q);
          end else begin
            a_vld    = 1'b1;
            mode_d   = MODE_IDLE;
            do_start = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha || is_digit) begin
            cand_d = kw_filter(cand_q, len_q, byte_i);
            len_d  = sat_inc(len_q);
          end else begin
            a_vld    = 1'b1;
            mode_d   = MODE_IDLE;
            do_start = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (byte_i == ChSlash) begin
            mode_d = MODE_COMMENT;
          end else begin
            a_vld    = 1'b1;
            mode_d   = MODE_IDLE;
            do_start = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (byte_i == ChLf) begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          mode_d   = MODE_IDLE;
          do_start = 1'b1;
        end
      endcase

      if (do_start && !is_blank) begin
        if (is_digit) begin
          mode_d  = MODE_NUM;
          acc_d   = ValueW'(byte_i[3:0]);
          start_d = pos_q;
          len_d   = PosW'(1);
        end else if (is_alpha) begin
          mode_d  = MODE_IDENT;
          cand_d  = kw_filter({KwCount{1'b1}}, '0, byte_i);
          start_d = pos_q;
          len_d   = PosW'(1);
        end else if (byte_i == ChSlash) begin
          mode_d  = MODE_SLASH;
          start_d = pos_q;
          len_d   = PosW'(1);
        end else begin
          b_vld        = 1'b1;
          b_tok.kind   = symbol_kind(byte_i);
          b_tok.start  = to_tok(pos_q);
          b_tok.length = TokPosW'(1);
        end
      end
    end
  end

  always_comb begin
    push_o             = '0;
    push_o.count       = accept_i ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
    push_o.first.tok   = a_vld ? a_tok : b_tok;
    push_o.first.last  = !(a_vld && b_vld);
    push_o.second.tok  = b_tok;
    push_o.second.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      cand_q  <= '0;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      cand_q  <= cand_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/stl_token_fifo.sv =====
module stl_token_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stl_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output stl_pkg::beat_t beat_o
);
  import stl_pkg::*;

  beat_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign beat_o  = mem_q[rd_ptr_q];
  assign cnt_d   = cnt_q + FifoCntW'(push_i.count) - FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/source_token_lexer.sv =====
// Source token lexer.
// Slave stream: one text byte per beat in s_axis_tdata; s_axis_tuser high marks
// an end beat that carries no byte, flushes the pending token, adds an EOF token
// and returns the lexer to its reset state.
// Master stream: one token per beat (kind, value, start, length in tdata);
// m_axis_tlast marks the final token caused by one input beat.
// A token completed by an input beat is written into the token queue when that
// beat is taken, and reaches the master side behind any tokens already queued.
// Throughput: with m_axis_tready held high, one input beat per cycle while each
// beat yields at most one token; a beat that yields two tokens costs two
// master beats, so the 4-entry token queue sets one token per cycle on the master side.
// s_axis_tready is high while the queue has room for two tokens; a stalled
// master side fills the queue and then holds off the slave side.
// Reset clears the lexer state and empties the queue; no clearing pass is run.
module source_token_lexer #(
  parameter int unsigned SourceBytes = stl_pkg::SourceBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  logic        s_axis_tuser,   // [0] end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [4:0] kind, [35:5] value, [48:36] start,
                                      // [61:49] length, [63:62] zero
  output logic        m_axis_tlast    // last_of_run
);
  import stl_pkg::*;

  push_t push;
  beat_t beat;
  logic  room;
  logic  accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  stl_lexer_core #(
    .SourceBytes(SourceBytes)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .eos_i   (s_axis_tuser),
    .push_o  (push)
  );

  stl_token_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .beat_o (beat)
  );

  assign m_axis_tdata = {2'b00, beat.tok.length, beat.tok.start, beat.tok.value,
                         beat.tok.kind};
  assign m_axis_tlast = beat.last;

endmodule
